// ----- sv/tdc_pkg.sv -----
`timescale 1ns / 1ps
package tdc_pkg;
  typedef enum logic [1:0] {
    OUT_UNCHANGED = 2'd0,
    OUT_REMAP     = 2'd1,
    OUT_FILL      = 2'd2,
    OUT_REPLACE   = 2'd3
  } outcome_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POS_RD,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DECIDE,
    ST_OWN_RD,
    ST_OWN_CHK,
    ST_MIN,
    ST_MIN_LAST,
    ST_WRITE
  } state_e;

  localparam logic [0:0] REG_SLOT_LIMIT = 1'b0;
  localparam logic [0:0] REG_MAP_TILES  = 1'b1;
endpackage

// ----- sv/tdc_slot_mem.sv -----
`timescale 1ns / 1ps
// Slot store: checksum and age per slot, one read and one write port.
module tdc_slot_mem #(
  parameter int SlotDepth = 256,
  parameter int AgeBits   = 48
) (
  input  logic                         clk_i,
  input  logic [$clog2(SlotDepth)-1:0] rd_addr_i,
  output logic [63:0]                  rd_sum_o,
  output logic [AgeBits-1:0]           rd_age_o,
  input  logic                         wr_en_i,
  input  logic [$clog2(SlotDepth)-1:0] wr_addr_i,
  input  logic [63:0]                  wr_sum_i,
  input  logic [AgeBits-1:0]           wr_age_i
);
  logic [63:0]        sum_mem [SlotDepth];
  logic [AgeBits-1:0] age_mem [SlotDepth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      sum_mem[wr_addr_i] <= wr_sum_i;
      age_mem[wr_addr_i] <= wr_age_i;
    end
    rd_sum_o <= sum_mem[rd_addr_i];
    rd_age_o <= age_mem[rd_addr_i];
  end
endmodule

// ----- sv/tdc_map_mem.sv -----
`timescale 1ns / 1ps
// Position map: slot index plus valid flag per tile position.
module tdc_map_mem #(
  parameter int MapDepth = 4096,
  parameter int EntBits  = 9
) (
  input  logic                        clk_i,
  input  logic [$clog2(MapDepth)-1:0] rd_addr_i,
  output logic [EntBits-1:0]          rd_data_o,
  input  logic                        wr_en_i,
  input  logic [$clog2(MapDepth)-1:0] wr_addr_i,
  input  logic [EntBits-1:0]          wr_data_i
);
  logic [EntBits-1:0] mem [MapDepth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    rd_data_o <= mem[rd_addr_i];
  end
endmodule

// ----- sv/tile_dedup_cache_policy_top.sv -----
`timescale 1ns / 1ps
// Tile deduplication cache policy. Each request carries a tile checksum and
// its screen position, and the block answers with one result saying which
// cache slot the position now shows and whether pixels and/or the mapping
// must be written. Slot state (checksum, age) lives in one synchronous RAM and
// the position map in a second RAM, each with a registered read. One request
// is handled at a time: a position read, a linear scan over the filled slots
// (one slot per cycle), and on a full-cache miss an own-slot check and, if
// the own slot cannot be reused, a second scan for the oldest age. After
// reset the position map is cleared one entry per cycle, during which no
// request is accepted; configuration writes are taken at any time.
module tile_dedup_cache_policy_top
  import tdc_pkg::*;
#(
  parameter int SlotDepth = 256,
  parameter int MapDepth  = 4096,
  parameter int AgeBits   = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: tile_checksum[63:0], tile_pos[75:64], zero fill to 80 bits.
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: outcome[1:0], slot[9:2], write_pixels[10], write_mapping[11].
  output logic [15:0] m_axis_tdata
);
  localparam int SW = $clog2(SlotDepth);
  localparam int MW = (MapDepth > 1) ? $clog2(MapDepth) : 1;
  localparam int CW = SW + 1;

  state_e state_q, state_d;
  logic [8:0]  limit_q;
  logic [12:0] tiles_q;
  logic [AgeBits-1:0] age_q, age_d;
  logic [CW-1:0] used_q, used_d;
  logic [MW-1:0] clr_q, clr_d;
  logic [63:0] sum_q, sum_d;
  logic [MW-1:0] pos_q, pos_d;
  logic [SW:0] own_q, own_d;
  logic        own_v_q, own_v_d;
  logic [CW-1:0] idx_q, idx_d;
  logic        found_q, found_d;
  logic [SW-1:0] hit_q, hit_d;
  logic [SW-1:0] best_q, best_d;
  logic [AgeBits-1:0] best_age_q, best_age_d;
  logic [1:0]  oc_q, oc_d;
  logic [SW-1:0] sl_q, sl_d;
  logic        wp_q, wp_d, wm_q, wm_d;
  logic        ov_q, ov_d;

  logic [SW-1:0] s_rd_addr, s_wr_addr;
  logic [63:0] s_rd_sum;
  logic [AgeBits-1:0] s_rd_age, thr;
  logic        s_we;
  logic [MW-1:0] m_rd_addr, m_wr_addr;
  logic [SW:0] m_rd_data, m_wr_data;
  logic        m_we;
  logic [CW-1:0] eff_limit;
  logic [CW:0] lim_ext;

  tdc_slot_mem #(.SlotDepth(SlotDepth), .AgeBits(AgeBits)) u_slot (
    .clk_i, .rd_addr_i(s_rd_addr), .rd_sum_o(s_rd_sum), .rd_age_o(s_rd_age),
    .wr_en_i(s_we), .wr_addr_i(s_wr_addr), .wr_sum_i(sum_q), .wr_age_i(age_q)
  );

  tdc_map_mem #(.MapDepth(MapDepth), .EntBits(SW + 1)) u_map (
    .clk_i, .rd_addr_i(m_rd_addr), .rd_data_o(m_rd_data),
    .wr_en_i(m_we), .wr_addr_i(m_wr_addr), .wr_data_i(m_wr_data)
  );

  // Clamp of the slot limit to the range 1..SlotDepth.
  always_comb begin
    lim_ext = (CW + 1)'(limit_q);
    if (limit_q == 9'd0) eff_limit = CW'(1);
    else if (lim_ext > (CW + 1)'(SlotDepth)) eff_limit = CW'(SlotDepth);
    else eff_limit = CW'(limit_q);
    thr = (age_q > AgeBits'(tiles_q)) ? age_q - AgeBits'(tiles_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 9'd256;
      tiles_q <= 13'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SLOT_LIMIT: limit_q <= cfg_wdata_i[8:0];
        REG_MAP_TILES:  tiles_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      age_q   <= '0;
      used_q  <= '0;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      age_q   <= age_d;
      used_q  <= used_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d; pos_q <= pos_d; own_q <= own_d; own_v_q <= own_v_d;
    idx_q <= idx_d; found_q <= found_d; hit_q <= hit_d; best_q <= best_d;
    best_age_q <= best_age_d; oc_q <= oc_d; sl_q <= sl_d;
    wp_q <= wp_d; wm_q <= wm_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'b0, wm_q, wp_q, 8'(sl_q), oc_q};

  always_comb begin
    state_d = state_q; age_d = age_q; used_d = used_q; clr_d = clr_q;
    sum_d = sum_q; pos_d = pos_q; own_d = own_q; own_v_d = own_v_q;
    idx_d = idx_q; found_d = found_q; hit_d = hit_q; best_d = best_q;
    best_age_d = best_age_q; oc_d = oc_q; sl_d = sl_q; wp_d = wp_q;
    wm_d = wm_q; ov_d = ov_q;
    s_rd_addr = idx_q[SW-1:0];
    s_we = 1'b0; s_wr_addr = sl_q;
    m_rd_addr = pos_q; m_we = 1'b0; m_wr_addr = pos_q;
    m_wr_data = {1'b1, sl_q};

    if (ov_q && m_axis_tready) ov_d = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        m_we = 1'b1; m_wr_addr = clr_q; m_wr_data = '0;
        clr_d = clr_q + MW'(1);
        if (clr_q == MW'(MapDepth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          sum_d = s_axis_tdata[63:0];
          // MapDepth is a power of two, so the position wraps by masking.
          pos_d = MW'(s_axis_tdata[75:64] & 12'(MapDepth - 1));
          age_d = age_q + AgeBits'(1);
          idx_d = '0; found_d = 1'b0;
          state_d = ST_POS_RD;
        end
      end
      ST_POS_RD: begin
        m_rd_addr = pos_q;
        s_rd_addr = '0;
        idx_d = CW'(1);
        state_d = (used_q == '0) ? ST_DECIDE : ST_SCAN;
      end
      ST_SCAN: begin
        // Slot idx_q-1 data arrives now; next address issued.
        if (idx_q == CW'(1)) begin
          own_d = m_rd_data[SW:0];
          own_v_d = m_rd_data[SW];
        end
        if (!found_q && s_rd_sum == sum_q) begin
          found_d = 1'b1; hit_d = SW'(idx_q - CW'(1));
        end
        if (idx_q == used_q) state_d = ST_DECIDE;
        else idx_d = idx_q + CW'(1);
      end
      ST_DECIDE: begin
        if (used_q == '0) begin
          own_d = m_rd_data[SW:0]; own_v_d = m_rd_data[SW];
        end
        if (found_q) begin
          sl_d = hit_q; wp_d = 1'b0;
          if (own_v_q && own_q[SW-1:0] == hit_q && used_q != '0) begin
            oc_d = OUT_UNCHANGED; wm_d = 1'b0;
          end else begin
            oc_d = OUT_REMAP; wm_d = 1'b1;
          end
          state_d = ST_WRITE;
        end else if (used_q < eff_limit) begin
          sl_d = SW'(used_q); used_d = used_q + CW'(1);
          oc_d = OUT_FILL; wp_d = 1'b1; wm_d = 1'b1;
          state_d = ST_WRITE;
        end else begin
          s_rd_addr = own_q[SW-1:0];
          state_d = ST_OWN_RD;
        end
      end
      ST_OWN_RD: begin
        s_rd_addr = own_q[SW-1:0];
        state_d = ST_OWN_CHK;
      end
      ST_OWN_CHK: begin
        oc_d = OUT_REPLACE; wp_d = 1'b1;
        if (own_v_q && CW'(own_q[SW-1:0]) < used_q && s_rd_age < thr) begin
          sl_d = own_q[SW-1:0]; wm_d = 1'b0;
          state_d = ST_WRITE;
        end else begin
          wm_d = 1'b1; s_rd_addr = '0; idx_d = CW'(1);
          best_d = '0;
          state_d = ST_MIN;
        end
      end
      ST_MIN: begin
        if (idx_q == CW'(1) || s_rd_age < best_age_q) begin
          best_age_d = s_rd_age; best_d = SW'(idx_q - CW'(1));
        end
        if (idx_q == used_q) state_d = ST_MIN_LAST;
        else idx_d = idx_q + CW'(1);
      end
      ST_MIN_LAST: begin
        sl_d = best_q;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        s_we = (oc_q != OUT_REMAP && oc_q != OUT_UNCHANGED) || found_q;
        m_we = wm_q;
        ov_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    s_rd_addr = (state_q == ST_SCAN || state_q == ST_MIN) ?
                SW'(idx_q) : s_rd_addr;
    if (state_q == ST_SCAN && idx_q == used_q) s_rd_addr = idx_q[SW-1:0];
  end

  // A result is shown only once the write-back step has run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_WRITE)
    else $error("result without write-back");
  // The fill count never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(SlotDepth))
    else $error("slot count overflow");
  // A fill always reports both pixel and mapping writes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && oc_q == OUT_FILL |-> wp_q && wm_q)
    else $error("fill flags wrong");
endmodule
